>>> rtl/bmc_pkg.sv
// ----------------------------------------------------------------------------
// bmc_pkg: shared types and constants for the box move clamp
// Field widths, request and register codes, and the records that travel
// along the barrier cell chain.
// ----------------------------------------------------------------------------
package bmc_pkg;

   localparam int CoordW   = 20;          // Q11.8 coordinate
   localparam int GeomW    = 22;          // center +/- half extent
   localparam int TargetW  = 24;          // walk target, never saturated midway
   localparam int WideW    = TargetW + 2; // compare and clamp arithmetic
   localparam int CountW   = 5;
   localparam int SizeW    = 18;
   localparam int StrW     = 2;
   localparam int IndexW   = 4;
   localparam int FuncW    = 2;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW = 20;

   localparam int DefaultVertDepth  = 16;
   localparam int DefaultHorizDepth = 16;

   // request codes
   localparam logic [FuncW-1:0] FuncLoadVert  = 2'd0;
   localparam logic [FuncW-1:0] FuncLoadHoriz = 2'd1;
   localparam logic [FuncW-1:0] FuncMove      = 2'd2;

   // register indexes
   localparam logic [CsrIndexW-1:0] CsrVertCount  = 3'd0;
   localparam logic [CsrIndexW-1:0] CsrHorizCount = 3'd1;
   localparam logic [CsrIndexW-1:0] CsrBoxSizeX   = 3'd2;
   localparam logic [CsrIndexW-1:0] CsrBoxSizeY   = 3'd3;
   localparam logic [CsrIndexW-1:0] CsrBoxCenterX = 3'd4;
   localparam logic [CsrIndexW-1:0] CsrBoxCenterY = 3'd5;

   typedef logic signed [CoordW-1:0]  coord_type;
   typedef logic signed [GeomW-1:0]   geom_type;
   typedef logic signed [TargetW-1:0] target_type;
   typedef logic signed [WideW-1:0]   wide_type;

   typedef struct packed {
      coord_type         position;
      coord_type         span_low;
      coord_type         span_high;
      logic [StrW-1:0]   strength;
   } entry_type;

   // table write broadcast to all cells
   typedef struct packed {
      logic              vert_en;
      logic              horiz_en;
      logic [IndexW-1:0] index;
      entry_type         entry;
   } write_type;

   // per-move values held steady for the whole walk
   typedef struct packed {
      coord_type         pos_x;
      coord_type         pos_y;
      logic [StrW-1:0]   strength;
      geom_type          hp_x;
      geom_type          hm_x;
      geom_type          hp_y;
      geom_type          hm_y;
      logic [CountW-1:0] vert_count;
      logic [CountW-1:0] horiz_count;
   } walk_type;

   // token handed from cell to cell
   typedef struct packed {
      logic       valid;
      target_type tx;
      target_type ty;
      logic       hit;
   } token_type;

   typedef struct packed {
      logic       hit;
      target_type target;
   } clamp_type;

endpackage

>>> rtl/bmc_cell.sv
// ----------------------------------------------------------------------------
// bmc_cell: one barrier cell
// Holds one vertical and one horizontal barrier entry and clamps the passing
// move token against both, then registers the token for the next cell.
// ----------------------------------------------------------------------------
module bmc_cell
   import bmc_pkg::*;
#(
   parameter int CELL_INDEX = 0,
   parameter bit HAS_VERT   = 1'b1,
   parameter bit HAS_HORIZ  = 1'b1
) (
   input  logic      clock,
   input  logic      reset,
   input  write_type wr,
   input  walk_type  walk,
   input  token_type tok_prev,
   output token_type tok_next
);

   entry_type vert_ff;
   entry_type horiz_ff;
   token_type tok_ff;
   token_type tok_in;
   clamp_type x_res;
   clamp_type y_res;
   logic      slot_match;
   logic      vert_active;
   logic      horiz_active;

   function automatic clamp_type axis_clamp(
      input logic       active,
      input coord_type  along,
      input coord_type  across,
      input target_type target,
      input geom_type   hp,
      input geom_type   hm,
      input entry_type  e,
      input logic [StrW-1:0] strength
   );
      wide_type  t;
      wide_type  p;
      clamp_type r;
      t = wide_type'(target);
      p = wide_type'(e.position);
      r.hit = 1'b0;
      if (active && strength <= e.strength &&
          across >= e.span_low && across <= e.span_high) begin
         if (along <= e.position && t + wide_type'(hp) > p) begin
            t = p - wide_type'(1) - wide_type'(hp);
            r.hit = 1'b1;
         end
         if (along >= e.position && t + wide_type'(hm) < p) begin
            t = p + wide_type'(1) - wide_type'(hm);
            r.hit = 1'b1;
         end
      end
      r.target = target_type'(t);
      return r;
   endfunction

   assign slot_match   = (32'(wr.index) == 32'(CELL_INDEX));
   assign vert_active  = HAS_VERT  && (32'(walk.vert_count)  > 32'(CELL_INDEX));
   assign horiz_active = HAS_HORIZ && (32'(walk.horiz_count) > 32'(CELL_INDEX));

   always_ff @(posedge clock) begin
      if (wr.vert_en && HAS_VERT && slot_match) begin
         vert_ff <= wr.entry;
      end
      if (wr.horiz_en && HAS_HORIZ && slot_match) begin
         horiz_ff <= wr.entry;
      end
   end

   // x and y walks are independent; only the hit flag is shared
   always_comb begin
      x_res = axis_clamp(vert_active, walk.pos_x, walk.pos_y, tok_prev.tx,
                         walk.hp_x, walk.hm_x, vert_ff, walk.strength);
      y_res = axis_clamp(horiz_active, walk.pos_y, walk.pos_x, tok_prev.ty,
                         walk.hp_y, walk.hm_y, horiz_ff, walk.strength);
      tok_in       = tok_prev;
      tok_in.tx    = x_res.target;
      tok_in.ty    = y_res.target;
      tok_in.hit   = tok_prev.hit | x_res.hit | y_res.hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_next = tok_ff;

endmodule

>>> rtl/box_move_clamp_against_segments.sv
// ----------------------------------------------------------------------------
// box_move_clamp_against_segments: clamp a moving box against barriers
// Two loadable barrier tables held in a chain of cells; a move token walks
// the chain and comes out clamped and saturated.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a clock edge with start high and busy low.
//   req_func selects a vertical load, a horizontal load or a move; code 3 is
//   dropped. A load writes one table slot at that edge and returns nothing;
//   busy stays low, so loads go one per cycle. A move raises busy and sends
//   a token down a chain of N = max(VERT_DEPTH, HORIZ_DEPTH) cells, one cell
//   per cycle, cell i holding slot i of each table deep enough for it. The
//   x and y walks run side by side in the same cells. rsp_valid is high for
//   one cycle, registered from the last cell's token; busy drops in that
//   cycle, so a new request may be taken at the edge ending it. No request
//   is taken while a move walks the chain. The receiver cannot stall: the
//   result is shown once and lost if unused. The csr_ port writes registers
//   at a clock edge and is to be used only while idle; the block does not
//   enforce this. Reset clears registers, busy and the token chain; table
//   contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module box_move_clamp_against_segments
   import bmc_pkg::*;
#(
   parameter int VERT_DEPTH  = DefaultVertDepth,
   parameter int HORIZ_DEPTH = DefaultHorizDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FuncW-1:0]      req_func,
   input  logic [IndexW-1:0]     req_entry_index,
   input  logic signed [CoordW-1:0] req_bar_position,
   input  logic signed [CoordW-1:0] req_bar_span_low,
   input  logic signed [CoordW-1:0] req_bar_span_high,
   input  logic [StrW-1:0]       req_bar_strength,
   input  logic signed [CoordW-1:0] req_pos_x,
   input  logic signed [CoordW-1:0] req_pos_y,
   input  logic signed [CoordW-1:0] req_step_x,
   input  logic signed [CoordW-1:0] req_step_y,
   input  logic [StrW-1:0]       req_mover_strength,
   output logic                  rsp_valid,
   output logic signed [CoordW-1:0] rsp_new_x,
   output logic signed [CoordW-1:0] rsp_new_y,
   output logic                  rsp_blocked,
   input  logic                  csr_write_en,
   input  logic [CsrIndexW-1:0]  csr_index,
   input  logic [CsrDataW-1:0]   csr_write_data
);

   localparam int NumCells = (VERT_DEPTH > HORIZ_DEPTH) ? VERT_DEPTH : HORIZ_DEPTH;

   logic [CountW-1:0] vert_count_ff;
   logic [CountW-1:0] horiz_count_ff;
   logic [SizeW-1:0]  size_x_ff;
   logic [SizeW-1:0]  size_y_ff;
   coord_type         center_x_ff;
   coord_type         center_y_ff;

   logic       busy_ff;
   logic       accept;
   logic       move_accept;
   write_type  wr;
   walk_type   walk_ff;
   walk_type   walk_in;
   token_type  tok0_ff;
   token_type  tok0_in;
   token_type  chain [NumCells+1];
   token_type  last;
   geom_type   half_x;
   geom_type   half_y;

   logic       rsp_valid_ff;
   coord_type  new_x_ff;
   coord_type  new_y_ff;
   logic       blocked_ff;

   function automatic coord_type sat_coord(input target_type v);
      coord_type r;
      if (v > target_type'(coord_type'({1'b0, {(CoordW-1){1'b1}}}))) begin
         r = {1'b0, {(CoordW-1){1'b1}}};
      end else if (v < target_type'(coord_type'({1'b1, {(CoordW-1){1'b0}}}))) begin
         r = {1'b1, {(CoordW-1){1'b0}}};
      end else begin
         r = coord_type'(v);
      end
      return r;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vert_count_ff  <= '0;
         horiz_count_ff <= '0;
         size_x_ff      <= '0;
         size_y_ff      <= '0;
         center_x_ff    <= '0;
         center_y_ff    <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CsrVertCount:  vert_count_ff  <= csr_write_data[CountW-1:0];
            CsrHorizCount: horiz_count_ff <= csr_write_data[CountW-1:0];
            CsrBoxSizeX:   size_x_ff      <= csr_write_data[SizeW-1:0];
            CsrBoxSizeY:   size_y_ff      <= csr_write_data[SizeW-1:0];
            CsrBoxCenterX: center_x_ff    <= coord_type'(csr_write_data[CoordW-1:0]);
            CsrBoxCenterY: center_y_ff    <= coord_type'(csr_write_data[CoordW-1:0]);
            default: ;
         endcase
      end
   end

   assign accept      = start && !busy_ff;
   assign move_accept = accept && (req_func == FuncMove);

   // table load broadcast
   always_comb begin
      wr.vert_en            = accept && (req_func == FuncLoadVert);
      wr.horiz_en           = accept && (req_func == FuncLoadHoriz);
      wr.index              = req_entry_index;
      wr.entry.position     = req_bar_position;
      wr.entry.span_low     = req_bar_span_low;
      wr.entry.span_high    = req_bar_span_high;
      wr.entry.strength     = req_bar_strength;
   end

   // half extent is size >> 1
   assign half_x = geom_type'({1'b0, size_x_ff[SizeW-1:1]});
   assign half_y = geom_type'({1'b0, size_y_ff[SizeW-1:1]});

   always_comb begin
      walk_in             = walk_ff;
      tok0_in             = tok0_ff;
      tok0_in.valid       = move_accept;
      if (move_accept) begin
         walk_in.pos_x       = req_pos_x;
         walk_in.pos_y       = req_pos_y;
         walk_in.strength    = req_mover_strength;
         walk_in.hp_x        = geom_type'(center_x_ff) + half_x;
         walk_in.hm_x        = geom_type'(center_x_ff) - half_x;
         walk_in.hp_y        = geom_type'(center_y_ff) + half_y;
         walk_in.hm_y        = geom_type'(center_y_ff) - half_y;
         walk_in.vert_count  = vert_count_ff;
         walk_in.horiz_count = horiz_count_ff;
         tok0_in.tx  = target_type'(req_pos_x) + target_type'(req_step_x);
         tok0_in.ty  = target_type'(req_pos_y) + target_type'(req_step_y);
         tok0_in.hit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok0_ff.valid <= 1'b0;
      end else begin
         tok0_ff <= tok0_in;
      end
   end

   assign chain[0] = tok0_ff;

   for (genvar i = 0; i < NumCells; i++) begin : g_cell
      bmc_cell #(
         .CELL_INDEX (i),
         .HAS_VERT   (i < VERT_DEPTH),
         .HAS_HORIZ  (i < HORIZ_DEPTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr       (wr),
         .walk     (walk_ff),
         .tok_prev (chain[i]),
         .tok_next (chain[i+1])
      );
   end

   assign last = chain[NumCells];

   // busy falls together with the rise of rsp_valid
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last.valid;
         if (move_accept) begin
            busy_ff <= 1'b1;
         end else if (last.valid) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (last.valid) begin
         new_x_ff   <= sat_coord(last.tx);
         new_y_ff   <= sat_coord(last.ty);
         blocked_ff <= last.hit;
      end
   end

   assign busy        = busy_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_new_x   = new_x_ff;
   assign rsp_new_y   = new_y_ff;
   assign rsp_blocked = blocked_ff;

endmodule
